// ----- hdl/qat_pkg.sv -----
// shared constants, codes and types of the quorum ack tracker
package qat_pkg;

    localparam int SLOTS     = 64;
    localparam int REPLICAS  = 3;

    localparam int SLOT_W    = 6;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int ACTION_W  = 3;
    localparam int REPL_W    = 3;
    localparam int ACK_W     = 2;
    localparam int ACKS_W    = ACK_W * REPLICAS;
    localparam int STATUS_W  = 3;
    localparam int TIME_W    = 32;
    localparam int QUORUM_W  = 4;
    localparam int CNT_W     = $clog2(REPLICAS + 1);
    localparam int ENTRY_W   = TIME_W + ACKS_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [QUORUM_W-1:0] QUORUM_RST  = QUORUM_W'(3);
    localparam logic [TIME_W-1:0]   TIMEOUT_RST = TIME_W'(1000);

    localparam logic [ACK_W-1:0] ACK_NONE     = 2'd0;
    localparam logic [ACK_W-1:0] ACK_SUCCESS  = 2'd1;
    localparam logic [ACK_W-1:0] ACK_NO_SPACE = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REGISTER = 3'd0,
        ACT_ACK      = 3'd1,
        ACT_TICK     = 3'd2,
        ACT_POLL     = 3'd3,
        ACT_RELEASE  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_FREE     = 3'd0,
        ST_PENDING  = 3'd1,
        ST_SUCCESS  = 3'd2,
        ST_MIX      = 3'd3,
        ST_NO_SPACE = 3'd4,
        ST_TIMEOUT  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUORUM  = 1'b0,
        CFG_TIMEOUT = 1'b1
    } t_cfg_idx;

endpackage

// ----- hdl/qat_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module qat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/quorum_ack_tracker_unit.sv -----
// quorum ack tracker: slot table of replicated writes with per-replica ack status
//
// usage notes
// - input channel (i_in_valid / o_in_stall) carries one transaction per item:
//   action, slot, replica and ack code; it is taken on a clock edge with
//   valid high and stall low
// - output channel (o_out_valid / i_out_stall) returns exactly one transaction
//   per item: the slot index and its status after the action was applied
// - results: the entry is read from memory at acceptance, modified in the work
//   stage and written back as the result is registered in the output register;
//   a new item is taken only after the work stage has passed its item on
// - a finished result waits in the output register, so the next item is taken
//   while the receiver stalls; a second result waits in the work stage and
//   input stall stays high until the output register frees up
// - config writes (quorum and timeout) go through i_cfg_we / i_cfg_index /
//   i_cfg_data and are taken on any edge with the enable high outside reset
// - reset (synchronous, active low) frees all slots at once through per-slot
//   busy flops, zeroes the tick counter and loads quorum 3, timeout 1000;
//   start stamps and acks in memory need no clearing, a slot is always
//   registered before it is busy
module quorum_ack_tracker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [qat_pkg::ACTION_W-1:0]   i_action,
    input  logic [qat_pkg::SLOT_W-1:0]     i_slot,
    input  logic [qat_pkg::REPL_W-1:0]     i_replica,
    input  logic [qat_pkg::ACK_W-1:0]      i_ack_code,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [qat_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [qat_pkg::STATUS_W-1:0]   o_status,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [qat_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qat_pkg::CFG_W-1:0]      i_cfg_data
);

    // configuration and time base
    logic [qat_pkg::QUORUM_W-1:0] r_quorum;
    logic [qat_pkg::TIME_W-1:0]   r_timeout;
    logic [qat_pkg::TIME_W-1:0]   r_time;

    // busy flag per slot, cleared at once by reset
    logic [qat_pkg::SLOTS-1:0]    r_busy;
    logic [qat_pkg::SLOTS-1:0]    n_busy;

    // work stage: item whose entry is being read from memory
    logic                         r_s1_vld;
    qat_pkg::t_action             r_s1_action;
    logic [qat_pkg::SLOT_W-1:0]   r_s1_slot;
    logic [qat_pkg::REPL_W-1:0]   r_s1_replica;
    logic [qat_pkg::ACK_W-1:0]    r_s1_code;

    // output register
    logic                         r_out_vld;
    logic [qat_pkg::SLOT_W-1:0]   r_out_slot;
    qat_pkg::t_status             r_out_status;

    logic                         in_acc;
    logic                         s1_done;
    logic                         s1_in_range;
    logic [qat_pkg::SLOT_AW-1:0]  s1_addr;

    // memory entry: {start stamp, ack codes}
    logic [qat_pkg::ENTRY_W-1:0]  rd_entry;
    logic [qat_pkg::ENTRY_W-1:0]  wr_entry;
    logic                         mem_we;
    logic [qat_pkg::TIME_W-1:0]   rd_start;
    logic [qat_pkg::ACKS_W-1:0]   rd_acks;
    logic [qat_pkg::TIME_W-1:0]   n_start;
    logic [qat_pkg::ACKS_W-1:0]   n_acks;
    logic                         busy_cur;
    logic                         busy_new;

    // status evaluation
    logic [qat_pkg::CNT_W-1:0]    cnt_good;
    logic [qat_pkg::CNT_W-1:0]    cnt_answered;
    logic                         differ;
    logic [qat_pkg::ACK_W-1:0]    first_code;
    logic [qat_pkg::ACK_W-1:0]    lane_code;
    logic [qat_pkg::TIME_W-1:0]   elapsed;
    qat_pkg::t_status             s1_status;

    // one item at a time; the work stage frees when the output register can take it
    assign o_in_stall = r_s1_vld;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign s1_done    = r_s1_vld && (!r_out_vld || !i_out_stall);

    assign s1_in_range = (32'(r_s1_slot) < 32'(qat_pkg::SLOTS));
    assign s1_addr     = r_s1_slot[qat_pkg::SLOT_AW-1:0];

    qat_ram #(
        .WIDTH (qat_pkg::ENTRY_W),
        .DEPTH (qat_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (s1_addr),
        .i_wdata (wr_entry),
        .i_re    (in_acc),
        .i_raddr (i_slot[qat_pkg::SLOT_AW-1:0]),
        .o_rdata (rd_entry)
    );

    assign rd_start = rd_entry[qat_pkg::ENTRY_W-1 -: qat_pkg::TIME_W];
    assign rd_acks  = rd_entry[qat_pkg::ACKS_W-1:0];
    assign busy_cur = r_busy[s1_addr];

    // modify step: apply the action to the entry read at acceptance
    always_comb begin
        n_start  = rd_start;
        n_acks   = rd_acks;
        busy_new = busy_cur;
        mem_we   = 1'b0;
        n_busy   = r_busy;
        if (s1_in_range) begin
            unique case (r_s1_action)
                qat_pkg::ACT_REGISTER: begin
                    n_start  = r_time;
                    n_acks   = '0;
                    busy_new = 1'b1;
                    mem_we   = s1_done;
                end
                qat_pkg::ACT_ACK: begin
                    // lanes beyond the replica count never match, so such acks drop
                    for (int r = 0; r < qat_pkg::REPLICAS; r++) begin
                        if (qat_pkg::REPL_W'(r) == r_s1_replica) begin
                            n_acks[r*qat_pkg::ACK_W +: qat_pkg::ACK_W] = r_s1_code;
                        end
                    end
                    mem_we = s1_done && busy_cur;
                end
                qat_pkg::ACT_RELEASE: begin
                    busy_new = 1'b0;
                end
                default: begin
                end
            endcase
            if (s1_done) begin
                n_busy[s1_addr] = busy_new;
            end
        end
    end

    assign wr_entry = {n_start, n_acks};

    // status of the updated entry
    always_comb begin
        cnt_good     = '0;
        cnt_answered = '0;
        differ       = 1'b0;
        first_code   = n_acks[qat_pkg::ACK_W-1:0];
        lane_code    = '0;
        for (int r = 0; r < qat_pkg::REPLICAS; r++) begin
            lane_code = n_acks[r*qat_pkg::ACK_W +: qat_pkg::ACK_W];
            if (lane_code != qat_pkg::ACK_NONE) begin
                cnt_answered = cnt_answered + qat_pkg::CNT_W'(1);
            end
            if (lane_code == qat_pkg::ACK_SUCCESS) begin
                cnt_good = cnt_good + qat_pkg::CNT_W'(1);
            end
            if (lane_code != first_code) begin
                differ = 1'b1;
            end
        end
    end

    // wrapping tick difference since registration
    assign elapsed = r_time - n_start;

    always_comb begin
        if (!s1_in_range || !busy_new) begin
            s1_status = qat_pkg::ST_FREE;
        end else if (32'(cnt_good) >= 32'(r_quorum)) begin
            s1_status = qat_pkg::ST_SUCCESS;
        end else if (32'(cnt_answered) == 32'(qat_pkg::REPLICAS) && differ) begin
            s1_status = qat_pkg::ST_MIX;
        end else if (32'(cnt_answered) == 32'(qat_pkg::REPLICAS)
                     && first_code == qat_pkg::ACK_NO_SPACE) begin
            s1_status = qat_pkg::ST_NO_SPACE;
        end else if (32'(cnt_answered) == 32'(qat_pkg::REPLICAS)
                     && first_code != qat_pkg::ACK_SUCCESS) begin
            // unanimous code three
            s1_status = qat_pkg::ST_MIX;
        end else if (elapsed >= r_timeout) begin
            s1_status = qat_pkg::ST_TIMEOUT;
        end else begin
            s1_status = qat_pkg::ST_PENDING;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quorum  <= qat_pkg::QUORUM_RST;
            r_timeout <= qat_pkg::TIMEOUT_RST;
            r_time    <= '0;
            r_busy    <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (qat_pkg::t_cfg_idx'(i_cfg_index))
                    qat_pkg::CFG_QUORUM:  r_quorum  <= i_cfg_data[qat_pkg::QUORUM_W-1:0];
                    qat_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[qat_pkg::TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
            // tick advances time at acceptance, before the slot is evaluated
            if (in_acc && qat_pkg::t_action'(i_action) == qat_pkg::ACT_TICK) begin
                r_time <= r_time + qat_pkg::TIME_W'(1);
            end
            r_busy <= n_busy;
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_action  <= qat_pkg::t_action'(i_action);
            r_s1_slot    <= i_slot;
            r_s1_replica <= i_replica;
            r_s1_code    <= i_ack_code;
        end
        if (s1_done) begin
            r_out_slot   <= r_s1_slot;
            r_out_status <= s1_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_slot_out  = r_out_slot;
    assign o_status    = r_out_status;

    // checks
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_vld))
        else $error("result appeared without an item in the work stage");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted transaction did not reach the work stage");

    a_release_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_action == qat_pkg::ACT_RELEASE)
            |=> (o_status == qat_pkg::ST_FREE))
        else $error("released slot not reported free");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == qat_pkg::ACT_TICK)
            |=> (r_time == $past(r_time) + qat_pkg::TIME_W'(1)))
        else $error("tick did not advance the time base");

endmodule

// ----- dv/testbench.sv -----
// testbench of the quorum ack tracker: slot-table predictor, stimulus tasks and result checks
`timescale 1ns / 100ps

module testbench;

    import qat_pkg::*;

    // action codes past release have no name in the package; they behave like a poll
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_MID   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;
    // the fourth ack code counts as an answer but never as a success
    localparam logic [ACK_W-1:0]    ACK_RESERVED     = 2'd3;
    localparam int                  HOT_SLOTS        = 4;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } slot_report_t;

    // dut signals; the inputs are driven to known values from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [ACTION_W-1:0]   in_action   = '0;
    logic [SLOT_W-1:0]     in_slot     = '0;
    logic [REPL_W-1:0]     in_replica  = '0;
    logic [ACK_W-1:0]      in_ack_code = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [SLOT_W-1:0]     slot_out;
    logic [STATUS_W-1:0]   status_out;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_data    = '0;

    quorum_ack_tracker_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_action    (in_action),
        .i_slot      (in_slot),
        .i_replica   (in_replica),
        .i_ack_code  (in_ack_code),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_slot_out  (slot_out),
        .o_status    (status_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // hard limit: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: own copy of the slot table, tick counter and registers
    // ------------------------------------------------------------------
    bit                    slot_held  [SLOTS];
    logic [TIME_W-1:0]     slot_stamp [SLOTS];
    logic [ACK_W-1:0]      slot_acks  [SLOTS][REPLICAS];
    logic [TIME_W-1:0]     tick_count  = '0;
    logic [QUORUM_W-1:0]   quorum_need = QUORUM_RST;
    logic [TIME_W-1:0]     tick_limit  = TIMEOUT_RST;

    // results predicted for accepted transactions, oldest first
    slot_report_t          reports_due[$];
    slot_report_t          due_report;
    int                    mismatch_count = 0;
    int                    items_sent     = 0;

    // sender idling: bursts with random gaps, switchable off for gap-free stretches
    bit                    sender_gaps    = 1'b1;
    int                    burst_left     = 0;
    logic [SLOT_W-1:0]     hot_slots [HOT_SLOTS];

    // receiver: long hold-off on request, otherwise segments of random stall density
    int                    hold_request   = 0;
    int                    stall_pct      = 0;
    int                    segment_left   = 0;

    // status of one slot as the tracker should report it
    function automatic t_status slot_status_of(int s);
        int                answered;
        int                good;
        bit                differ;
        logic [TIME_W-1:0] elapsed;
        answered = 0;
        good     = 0;
        differ   = 1'b0;
        if (!slot_held[s])
            return ST_FREE;
        for (int r = 0; r < REPLICAS; r++) begin
            if (slot_acks[s][r] != ACK_NONE)
                answered++;
            if (slot_acks[s][r] == ACK_SUCCESS)
                good++;
            if (slot_acks[s][r] != slot_acks[s][0])
                differ = 1'b1;
        end
        if (good >= int'(quorum_need))
            return ST_SUCCESS;
        // every replica answered: unanimous success below quorum falls through
        if (answered == REPLICAS) begin
            if (differ)
                return ST_MIX;
            if (slot_acks[s][0] == ACK_NO_SPACE)
                return ST_NO_SPACE;
            if (slot_acks[s][0] != ACK_SUCCESS)
                return ST_MIX;
        end
        // elapsed ticks wrap modulo 2^32
        elapsed = tick_count - slot_stamp[s];
        if (elapsed >= tick_limit)
            return ST_TIMEOUT;
        return ST_PENDING;
    endfunction

    // apply one accepted transaction to the table and give its report
    function automatic slot_report_t track_item(logic [ACTION_W-1:0] act,
                                                logic [SLOT_W-1:0] slot,
                                                logic [REPL_W-1:0] repl,
                                                logic [ACK_W-1:0] code);
        slot_report_t rep;
        // time advances before the addressed slot is looked at
        if (act == ACT_TICK)
            tick_count = tick_count + 1'b1;
        case (act)
            ACT_REGISTER: begin
                for (int r = 0; r < REPLICAS; r++)
                    slot_acks[slot][r] = ACK_NONE;
                slot_stamp[slot] = tick_count;
                slot_held[slot]  = 1'b1;
            end
            ACT_ACK: begin
                // acks to free slots and to absent replicas are dropped
                if (slot_held[slot] && repl < REPLICAS)
                    slot_acks[slot][repl] = code;
            end
            ACT_RELEASE: begin
                slot_held[slot] = 1'b0;
            end
            default: ;
        endcase
        rep.slot   = slot;
        rep.status = slot_status_of(slot);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // result checker: one report per transaction, in order
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (reports_due.size() == 0) begin
                $error("unexpected result: slot_out %0d status %0d", slot_out, status_out);
                mismatch_count++;
            end else begin
                due_report = reports_due.pop_front();
                if (slot_out !== due_report.slot) begin
                    $error("slot_out mismatch: expected %0d, actual %0d",
                           due_report.slot, slot_out);
                    mismatch_count++;
                end
                if (status_out !== due_report.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           due_report.status, status_out);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (hold_request > 0) begin
            out_stall <= 1'b1;
            hold_request--;
        end else begin
            if (segment_left == 0) begin
                segment_left = $urandom_range(20, 120);
                stall_pct    = 30 * $urandom_range(0, 3);
            end
            segment_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------

    // offer one transaction, hold it until taken, then predict its report
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                             input logic [REPL_W-1:0] repl, input logic [ACK_W-1:0] code);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        in_valid    <= 1'b1;
        in_action   <= act;
        in_slot     <= slot;
        in_replica  <= repl;
        in_ack_code <= code;
        do
            @(posedge clk);
        while (in_stall);
        reports_due.push_back(track_item(act, slot, repl, code));
        items_sent++;
    endtask

    // stop offering and wait until every predicted report has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    // register writes only with the tracker idle
    task automatic write_config(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        wait_results_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_QUORUM:  quorum_need = data[QUORUM_W-1:0];
            CFG_TIMEOUT: tick_limit  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input int quorum, input logic [TIME_W-1:0] ticks);
        write_config(CFG_QUORUM, CFG_W'(quorum));
        write_config(CFG_TIMEOUT, ticks);
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic logic [ACK_W-1:0] pick_ack_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return ACK_SUCCESS;
        if (roll < 80)
            return ACK_NO_SPACE;
        if (roll < 90)
            return ACK_NONE;
        return ACK_RESERVED;
    endfunction

    // mostly real replicas, now and then an absent one past the last
    function automatic logic [REPL_W-1:0] pick_replica();
        if ($urandom_range(0, 9) == 0)
            return REPL_W'($urandom_range(REPLICAS, 7));
        return REPL_W'($urandom_range(0, REPLICAS - 1));
    endfunction

    // a few hot slots so that sequences meet each other's leftovers
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 9) < 7)
            return hot_slots[$urandom_range(0, HOT_SLOTS - 1)];
        return SLOT_W'($urandom_range(0, SLOTS - 1));
    endfunction

    task automatic send_noise();
        send_item(ACTION_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, SLOTS - 1)),
                  REPL_W'($urandom_range(0, 7)), ACK_W'($urandom_range(0, 3)));
    endtask

    // well-formed write lifecycles with random content, mixed with noise
    task automatic run_random_items(input int count);
        int                target;
        int                roll;
        logic [SLOT_W-1:0] s;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 80) begin
                s = pick_slot();
                send_item(ACT_REGISTER, s, REPL_W'($urandom_range(0, 7)),
                          ACK_W'($urandom_range(0, 3)));
                repeat ($urandom_range(2, 8)) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60)
                        send_item(ACT_ACK, s, pick_replica(), pick_ack_code());
                    else if (roll < 78)
                        send_item(ACT_TICK, pick_slot(), REPL_W'($urandom_range(0, 7)),
                                  ACK_W'($urandom_range(0, 3)));
                    else if (roll < 94)
                        send_item(ACT_POLL, s, REPL_W'($urandom_range(0, 7)),
                                  ACK_W'($urandom_range(0, 3)));
                    else
                        send_item(ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
                                  s, REPL_W'($urandom_range(0, 7)),
                                  ACK_W'($urandom_range(0, 3)));
                end
                if ($urandom_range(0, 1))
                    send_item(ACT_RELEASE, s, REPL_W'($urandom_range(0, 7)),
                              ACK_W'($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_noise();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // everything free after reset; acks, ticks and releases on free slots do nothing
    task automatic test_free_slots();
        send_item(ACT_POLL, 6'd0, 3'd0, ACK_NONE);
        send_item(ACT_POLL, 6'd63, 3'd7, ACK_RESERVED);
        send_item(ACT_ACK, 6'd5, 3'd0, ACK_SUCCESS);
        send_item(ACT_RELEASE, 6'd10, 3'd0, ACK_NONE);
        send_item(ACT_TICK, 6'd42, 3'd0, ACK_NONE);
    endtask

    // lifecycles under the reset quorum of three
    task automatic test_slot_lifecycle();
        // quorum reached; acks to absent replicas are dropped on the way
        send_item(ACT_REGISTER, 6'd0, 3'd0, ACK_NONE);
        send_item(ACT_ACK, 6'd0, 3'd0, ACK_SUCCESS);
        send_item(ACT_ACK, 6'd0, 3'd7, ACK_SUCCESS);
        send_item(ACT_ACK, 6'd0, 3'd3, ACK_SUCCESS);
        send_item(ACT_ACK, 6'd0, 3'd1, ACK_SUCCESS);
        send_item(ACT_ACK, 6'd0, 3'd2, ACK_SUCCESS);
        // register on a busy slot clears its acks, then all out of space
        send_item(ACT_REGISTER, 6'd0, 3'd0, ACK_NONE);
        send_item(ACT_ACK, 6'd0, 3'd0, ACK_NO_SPACE);
        send_item(ACT_ACK, 6'd0, 3'd1, ACK_NO_SPACE);
        send_item(ACT_ACK, 6'd0, 3'd2, ACK_NO_SPACE);
        // answers that differ give error mix
        send_item(ACT_ACK, 6'd0, 3'd1, ACK_SUCCESS);
        // all replicas answer with the reserved code
        send_item(ACT_REGISTER, 6'd63, 3'd0, ACK_NONE);
        send_item(ACT_ACK, 6'd63, 3'd0, ACK_RESERVED);
        send_item(ACT_ACK, 6'd63, 3'd1, ACK_RESERVED);
        send_item(ACT_ACK, 6'd63, 3'd2, ACK_RESERVED);
        // unused actions report like a poll
        send_item(ACT_UNUSED_FIRST, 6'd63, 3'd0, ACK_NONE);
        send_item(ACT_UNUSED_MID, 6'd63, 3'd0, ACK_NONE);
        send_item(ACT_UNUSED_LAST, 6'd63, 3'd0, ACK_NONE);
        send_item(ACT_RELEASE, 6'd63, 3'd0, ACK_NONE);
    endtask

    // register extremes: zero timeout, quorum above the replica count, one-tick timeout
    task automatic test_config_extremes();
        set_config(8, 32'd0);
        // unanimous success below quorum drops to the time check
        send_item(ACT_REGISTER, 6'd4, 3'd0, ACK_NONE);
        send_item(ACT_ACK, 6'd4, 3'd0, ACK_SUCCESS);
        send_item(ACT_ACK, 6'd4, 3'd1, ACK_SUCCESS);
        send_item(ACT_ACK, 6'd4, 3'd2, ACK_SUCCESS);
        set_config(1, 32'd1);
        send_item(ACT_REGISTER, 6'd5, 3'd0, ACK_NONE);
        send_item(ACT_TICK, 6'd5, 3'd0, ACK_NONE);
        send_item(ACT_ACK, 6'd5, 3'd2, ACK_SUCCESS);
    endtask

    // receiver holds off long while the sender keeps offering back to back
    task automatic test_output_hold_off();
        wait_results_drained();
        sender_gaps  = 1'b0;
        hold_request = 300;
        repeat (24)
            send_noise();
        sender_gaps = 1'b1;
    endtask

    // sender pauses mid-stream until every report is back
    task automatic test_drain_pause();
        run_random_items(20);
        wait_results_drained();
        run_random_items(20);
    endtask

    // random lifecycles across several register settings, extremes included
    task automatic test_random_phases();
        int                quorum_set [6];
        logic [TIME_W-1:0] ticks_set  [6];
        quorum_set = '{1, 2, 3, 8, 0, 3};
        ticks_set  = '{32'd1, 32'd5, 32'd12, 32'hFFFF_FFFF, 32'd0, TIMEOUT_RST};
        // the fifth phase takes random values
        quorum_set[4] = $urandom_range(1, 8);
        ticks_set[4]  = $urandom_range(1, 40);
        for (int p = 0; p < 6; p++) begin
            set_config(quorum_set[p], ticks_set[p]);
            for (int h = 0; h < HOT_SLOTS; h++)
                hot_slots[h] = SLOT_W'($urandom_range(0, SLOTS - 1));
            // every second phase, starting with the second, runs without sender gaps
            sender_gaps = (p % 2 == 0);
            run_random_items(130);
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        for (int h = 0; h < HOT_SLOTS; h++)
            hot_slots[h] = SLOT_W'($urandom_range(0, SLOTS - 1));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_free_slots();
        test_slot_lifecycle();
        test_config_extremes();
        test_output_hold_off();
        test_drain_pause();
        test_random_phases();
        wait_results_drained();
        // a few more cycles to catch any stray result
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
